### hdl/pwpd_pkg.sv
// shared types, codes and constants for the pwm period and duty to timer settings block
package pwpd_pkg;

   localparam int unsigned NUM_CHANNELS_DEF  = 4;
   localparam int unsigned PRESCALER_MAX_DEF = 65535;
   localparam int unsigned COUNT_W           = 34;
   localparam logic [COUNT_W-1:0] NS_PER_SECOND = 34'd1000000000;
   // floor(2^62 / 1e9), reciprocal for the ns scaling
   localparam logic [32:0] NS_RECIP          = 33'd4611686018;
   localparam logic [31:0] CLOCK_RATE_RESET  = 32'd100000000;
   localparam logic [31:0] MAX_RELOAD_RESET  = 32'd65535;
   localparam logic [1:0]  CSR_CLOCK_RATE    = 2'd0;
   localparam logic [1:0]  CSR_MAX_RELOAD    = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BUSY    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic        want_enable;
      logic        invert_polarity;
      logic [30:0] period_len;
      logic [30:0] duty_ns;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] prescaler_out;
      logic [31:0] reload_out;
      logic [31:0] compare_out;
      logic [3:0]  enabled_mask;
      logic        counter_running;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REJECT,
      OP_DISABLE,
      OP_MUL_COUNT,
      OP_DIV_COUNT,
      OP_DIV_PSC,
      OP_DIV_PRD,
      OP_MUL_CMP,
      OP_DIV_CMP,
      OP_FAIL,
      OP_BUSY,
      OP_COMMIT,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic bad_channel;
      logic disable_path;
      logic psc_bad;
      logic prd_zero;
      logic busy;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_COUNT,
      ST_WAIT_COUNT,
      ST_DIV_PSC,
      ST_WAIT_PSC,
      ST_CHECK_PSC,
      ST_WAIT_PRD,
      ST_CHECK_PRD,
      ST_DIV_CMP,
      ST_WAIT_CMP,
      ST_COMMIT,
      ST_DONE
   } state_type;

endpackage

### hdl/pwm_period_duty_to_timer_settings.sv
// top level: pwm period and duty in ns to prescaler, reload and compare settings
//
//   port group   direction  handshake             payload
//   req_         in         req_valid/req_stall   req_word (req_type)
//   rsp_         out        rsp_valid/rsp_stall   rsp_word (rsp_type)
//   csr_         in         csr_wen               csr_index, csr_wdata
//
// one word at a time; a full apply scales by 1e9 with a reciprocal multiply and a
// short fix-up, then runs three divisions on one shared divider plus control steps
// disable and out-of-range channel words skip the scaling and the divisions
// synchronous active-high reset clears settings to their defaults
// a finished result waits in the rsp register while rsp_stall is high
module pwm_period_duty_to_timer_settings
   import pwpd_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS  = NUM_CHANNELS_DEF,
   parameter int unsigned PRESCALER_MAX = PRESCALER_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_word,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   pwpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwpd_datapath #(
      .NUM_CHANNELS  (NUM_CHANNELS),
      .PRESCALER_MAX (PRESCALER_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_word  (rsp_word)
   );

endmodule

### hdl/pwpd_div.sv
// restoring divider, one quotient bit per cycle, 64-bit dividend over 33-bit divisor
module pwpd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic [33:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [33:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff[32:0], dvd_ff[63]};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? (shifted - {1'b0, dvs_ff}) : shifted;
         dvd_in  = {dvd_ff[62:0], ge};
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

### hdl/pwpd_datapath.sv
// timer settings registers, multiplier, divider operand selection and result word
module pwpd_datapath
   import pwpd_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS  = NUM_CHANNELS_DEF,
   parameter int unsigned PRESCALER_MAX = PRESCALER_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_word,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output rsp_type     rsp_word
);

   logic [31:0]        clock_rate_ff;
   logic [31:0]        max_reload_ff;
   req_type            req_ff;
   logic [62:0]        product_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] psc_ff;
   logic [31:0]        prd_ff;
   logic [31:0]        cmp_ff;
   op_type             div_sel_ff;
   logic [15:0]        prescaler_ff;
   logic [31:0]        reload_ff;
   logic [31:0]        compare_ff [4];
   logic [3:0]         enable_ff, enable_in;
   logic               counter_ff, counter_in;
   logic [1:0]         status_ff;
   rsp_type            rsp_ff;
   logic               ns_mul_ff;
   logic               ns_fix_ff;
   logic [65:0]        ns_prod_ff;
   logic [COUNT_W-1:0] ns_q_ff;
   logic [COUNT_W-1:0] ns_rem_ff;

   logic [3:0]  ch_bit;
   logic [3:0]  chan_mask;
   logic [3:0]  others;
   logic        was_on;
   logic        div_start;
   logic [63:0] div_dividend;
   logic [32:0] div_divisor;
   logic [63:0] div_quotient;
   logic        div_done;
   logic        ns_done;
   logic [31:0] reload_new;

   always_comb begin
      ch_bit     = 4'b0001 << req_ff.channel;
      chan_mask  = 4'((5'd1 << NUM_CHANNELS) - 5'd1);
      others     = enable_ff & ~ch_bit & chan_mask;
      was_on     = |(enable_ff & ch_bit);
      reload_new = prd_ff - 32'd1;
      ns_done    = ns_fix_ff && (ns_rem_ff < NS_PER_SECOND);

      stat.div_done     = div_done || ns_done;
      stat.bad_channel  = {1'b0, req_ff.channel} >= 3'(NUM_CHANNELS);
      stat.disable_path = was_on && !req_ff.want_enable;
      stat.psc_bad      = psc_ff > COUNT_W'(PRESCALER_MAX);
      stat.prd_zero     = prd_ff == 32'd0;
      stat.busy         = (|others) &&
                          ((prescaler_ff != psc_ff[15:0]) || (reload_ff != reload_new));
   end

   always_comb begin
      div_start = 1'b1;
      unique case (cmd.op)
         OP_DIV_PSC: begin
            div_dividend = {30'd0, count_ff};
            div_divisor  = {1'b0, max_reload_ff} + 33'd1;
         end
         OP_DIV_PRD: begin
            div_dividend = {30'd0, count_ff};
            div_divisor  = {17'd0, psc_ff[15:0]} + 33'd1;
         end
         OP_DIV_CMP: begin
            div_dividend = {1'b0, product_ff};
            div_divisor  = {2'd0, req_ff.period_len};
         end
         default: begin
            div_start    = 1'b0;
            div_dividend = {1'b0, product_ff};
            div_divisor  = {2'd0, req_ff.period_len};
         end
      endcase
   end

   pwpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      enable_in  = enable_ff;
      counter_in = counter_ff;
      if (cmd.op == OP_DISABLE) begin
         enable_in = enable_ff & ~ch_bit & chan_mask;
         if (enable_in == 4'd0) begin
            counter_in = 1'b0;
         end
      end else if (cmd.op == OP_COMMIT && !was_on && req_ff.want_enable) begin
         enable_in  = enable_ff | ch_bit;
         counter_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_rate_ff <= CLOCK_RATE_RESET;
         max_reload_ff <= MAX_RELOAD_RESET;
         prescaler_ff  <= '0;
         reload_ff     <= '1;
         compare_ff    <= '{default: '0};
         enable_ff     <= '0;
         counter_ff    <= 1'b0;
         ns_mul_ff     <= 1'b0;
         ns_fix_ff     <= 1'b0;
      end else begin
         if (csr_wen && csr_index == CSR_CLOCK_RATE) begin
            clock_rate_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == CSR_MAX_RELOAD) begin
            max_reload_ff <= csr_wdata;
         end
         enable_ff  <= enable_in;
         counter_ff <= counter_in;
         ns_mul_ff  <= cmd.op == OP_DIV_COUNT;
         ns_fix_ff  <= ns_mul_ff || (ns_fix_ff && !ns_done);
         if (cmd.op == OP_COMMIT) begin
            prescaler_ff               <= psc_ff[15:0];
            reload_ff                  <= reload_new;
            compare_ff[req_ff.channel] <= cmp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         req_ff <= req_word;
      end
      if (cmd.op == OP_MUL_COUNT) begin
         product_ff <= 63'(clock_rate_ff) * 63'(req_ff.period_len);
      end else if (cmd.op == OP_MUL_CMP) begin
         product_ff <= 63'(prd_ff) * 63'(req_ff.duty_ns);
      end
      // ns scaling: quotient estimate low by at most four, then fix-up
      if (cmd.op == OP_DIV_COUNT) begin
         ns_prod_ff <= 66'(product_ff[62:30]) * 66'(NS_RECIP);
      end
      if (ns_mul_ff) begin
         ns_q_ff   <= ns_prod_ff[65:32];
         ns_rem_ff <= product_ff[COUNT_W-1:0] - ns_prod_ff[65:32] * NS_PER_SECOND;
      end else if (ns_fix_ff && !ns_done) begin
         ns_q_ff   <= ns_q_ff + COUNT_W'(1);
         ns_rem_ff <= ns_rem_ff - NS_PER_SECOND;
      end
      if (ns_done) begin
         count_ff <= ns_q_ff;
      end
      if (div_start) begin
         div_sel_ff <= cmd.op;
      end
      if (div_done) begin
         unique case (div_sel_ff)
            OP_DIV_PSC:   psc_ff   <= div_quotient[COUNT_W-1:0];
            OP_DIV_PRD:   prd_ff   <= div_quotient[31:0];
            default:      cmp_ff   <= div_quotient[31:0];
         endcase
      end
      unique case (cmd.op)
         OP_REJECT, OP_FAIL: status_ff <= STATUS_INVALID;
         OP_BUSY:            status_ff <= STATUS_BUSY;
         OP_DISABLE,
         OP_COMMIT:          status_ff <= STATUS_OK;
         default:            status_ff <= status_ff;
      endcase
      if (cmd.op == OP_RESPOND) begin
         rsp_ff.status          <= status_ff;
         rsp_ff.prescaler_out   <= prescaler_ff;
         rsp_ff.reload_out      <= reload_ff;
         rsp_ff.compare_out     <= stat.bad_channel ? 32'd0 : compare_ff[req_ff.channel];
         rsp_ff.enabled_mask    <= enable_ff;
         rsp_ff.counter_running <= counter_ff;
      end
   end

   assign rsp_word = rsp_ff;

`ifndef SYNTHESIS
   a_counter_tracks_enables: assert property (@(posedge clock) disable iff (reset)
      counter_ff == (|enable_ff))
      else $error("counter enable disagrees with channel enables");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_COMMIT |-> !stat.prd_zero && !stat.psc_bad)
      else $error("commit of invalid timebase");
`endif

endmodule

### hdl/pwpd_ctrl.sv
// sequencing state machine for one apply request and the result handshake
module pwpd_ctrl
   import pwpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   always_comb begin
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (stat.bad_channel) begin
               cmd.op   = OP_REJECT;
               state_in = ST_DONE;
            end else if (stat.disable_path) begin
               cmd.op   = OP_DISABLE;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_MUL_COUNT;
               state_in = ST_DIV_COUNT;
            end
         end
         ST_DIV_COUNT: begin
            cmd.op   = OP_DIV_COUNT;
            state_in = ST_WAIT_COUNT;
         end
         ST_WAIT_COUNT: begin
            if (stat.div_done) begin
               state_in = ST_DIV_PSC;
            end
         end
         ST_DIV_PSC: begin
            cmd.op   = OP_DIV_PSC;
            state_in = ST_WAIT_PSC;
         end
         ST_WAIT_PSC: begin
            if (stat.div_done) begin
               state_in = ST_CHECK_PSC;
            end
         end
         ST_CHECK_PSC: begin
            if (stat.psc_bad) begin
               cmd.op   = OP_FAIL;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_DIV_PRD;
               state_in = ST_WAIT_PRD;
            end
         end
         ST_WAIT_PRD: begin
            if (stat.div_done) begin
               state_in = ST_CHECK_PRD;
            end
         end
         ST_CHECK_PRD: begin
            priority if (stat.prd_zero) begin
               cmd.op   = OP_FAIL;
               state_in = ST_DONE;
            end else if (stat.busy) begin
               cmd.op   = OP_BUSY;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_MUL_CMP;
               state_in = ST_DIV_CMP;
            end
         end
         ST_DIV_CMP: begin
            cmd.op   = OP_DIV_CMP;
            state_in = ST_WAIT_CMP;
         end
         ST_WAIT_CMP: begin
            if (stat.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (cmd.op == OP_RESPOND) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CHECK)
      else $error("accepted word did not start processing");
`endif

endmodule
